@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define SDE_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("check failed");

// Antecedent implies consequent in the following cycle.
`define SDE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

@@ hw/rtl/sde_pkg.sv @@
package sde_pkg;

	localparam int SW = 24;
	localparam logic signed [SW-1:0] SMAX = 24'sh7FFFFF;
	localparam logic signed [SW-1:0] SMIN = 24'sh800000;
	localparam logic [16:0] ONE_C = 17'd65536;

	// reciprocals: floor(x/10) = (x*C10)>>25 for x < 2^22, floor(x/5) = (x*C5)>>30 for x < 2^27
	localparam logic signed [31:0] C10 = 32'sd3355444;
	localparam logic signed [31:0] C5 = 32'sd214748365;

	localparam logic signed [SW-1:0] VCA_CLAMP = 24'sd1310720;
	localparam logic signed [SW-1:0] DUCK_CLAMP = 24'sd327680;

	// register indexes
	localparam logic [2:0] REG_SIDE_GAIN = 3'd0;
	localparam logic [2:0] REG_DUCK_AMT = 3'd1;
	localparam logic [2:0] REG_DUCK_W = 3'd2;
	localparam logic [2:0] REG_DECAY = 3'd3;
	localparam logic [2:0] REG_ALPHA = 3'd4;
	localparam logic [2:0] REG_FSTEP = 3'd5;
	localparam logic [2:0] REG_FLEN = 3'd6;

	// sequencer steps
	localparam logic [4:0] STP_VGAIN = 5'd0;
	localparam logic [4:0] STP_VCA_L = 5'd1;
	localparam logic [4:0] STP_VCA_R = 5'd2;
	localparam logic [4:0] STP_VOL_L = 5'd3;
	localparam logic [4:0] STP_VOL_R = 5'd4;
	localparam logic [4:0] STP_FADE_L = 5'd5;
	localparam logic [4:0] STP_FADE_R = 5'd6;
	localparam logic [4:0] STP_PEAK_L = 5'd7;
	localparam logic [4:0] STP_PEAK_R = 5'd8;
	localparam logic [4:0] STP_SM_A = 5'd9;
	localparam logic [4:0] STP_SM_B = 5'd10;
	localparam logic [4:0] STP_ENV_L = 5'd11;
	localparam logic [4:0] STP_ENV_R = 5'd12;
	localparam logic [4:0] STP_DGAIN = 5'd13;
	localparam logic [4:0] STP_DUCK = 5'd14;
	localparam logic [4:0] STP_DPROD = 5'd15;
	localparam logic [4:0] STP_FACTOR = 5'd16;
	localparam logic [4:0] STP_OUT_L = 5'd17;
	localparam logic [4:0] STP_OUT_R = 5'd18;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	function automatic logic signed [63:0] rnd16(input logic signed [63:0] p);
		rnd16 = (p + 64'sd32768) >>> 16;
	endfunction

	function automatic logic signed [SW-1:0] sat_s(input logic signed [63:0] v);
		if (v > 64'(SMAX)) sat_s = SMAX;
		else if (v < 64'(SMIN)) sat_s = SMIN;
		else sat_s = v[SW-1:0];
	endfunction

endpackage

@@ hw/rtl/sidechain_ducking_envelope_unit.sv @@
// Sidechain ducking with envelope follower, one stereo sample per item.
// Input item on s_tvalid/s_tready/s_tdata/s_tuser: sidechain, main mix, mute
// button level and two control voltages, with their presence flags in tuser.
// Result item on m_tvalid/m_tready/m_tdata: ducked mix plus scaled sidechain,
// the raw envelope for a level meter and the mute state.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while the block is idle, and the block does not enforce this.
// One signed 32x32 multiplier is shared under a step counter; an item takes
// 19 multiply steps, one per cycle, then the done state hands the result to
// the output register and raises m_tvalid.
// s_tready is high only in idle. The output register holds a finished item
// while the next one is computed; if it is still not taken when the next
// result is ready, the sequencer waits and s_tready stays low.
// Reset: registers load their defaults, peaks and smoothed envelope clear,
// fade level goes to full, mute is off.
module sidechain_ducking_envelope_unit
	import sde_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// side_left, side_right, mix_left, mix_right, mute_pressed, vca_cv, duck_cv, pad
	input  logic [151:0] s_tdata,
	// vca_cv_present, duck_cv_present
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_left, out_right, envelope, muted
	output logic [71:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [17:0]  cfg_data
);

`include "assert_macros.svh"

	logic [17:0] side_gain_q;
	logic [16:0] duck_amount_q;
	logic signed [17:0] duck_w_q;
	logic [16:0] decay_q, alpha_q, fstep_q;
	logic [15:0] flen_q;

	state_t state_q;
	logic [4:0] step_q;

	logic signed [SW-1:0] sl_q, sr_q, ml_q, mr_q, vcv_q, dcv_q;
	logic vpres_q, dpres_q;
	logic [22:0] pl_q, pr_q, sm_q, env_q;
	logic [16:0] fade_q;
	logic [15:0] frem_q;
	logic mute_q, held_q;
	logic [17:0] g_q;
	logic [16:0] c_q;
	logic signed [19:0] duck_q;
	logic signed [27:0] z_q;
	logic signed [24:0] factor_q;
	logic signed [SW-1:0] ol_q, or_q;
	logic [71:0] mdata_q;
	logic mvalid_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod, r16;
	logic [23:0] env_sum;
	logic [16:0] alpha_c;
	logic signed [63:0] acc_q;
	logic signed [63:0] q5;
	logic signed [63:0] sm_nxt;

	// mute and fade update, evaluated at accept
	logic press;
	logic held_n, mute_n;
	logic [15:0] rem_a;
	logic signed [18:0] lvl_t;
	logic [16:0] fade_n;
	logic [15:0] frem_n;

	function automatic logic [22:0] abs_sat(input logic signed [SW-1:0] s);
		if (s == SMIN) abs_sat = SMAX[22:0];
		else if (s < 0) abs_sat = 23'(-s);
		else abs_sat = s[22:0];
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata = mdata_q;

	assign env_sum = {1'b0, pl_q} + {1'b0, pr_q};
	assign alpha_c = (alpha_q > ONE_C) ? ONE_C : alpha_q;
	assign prod = mul_a * mul_b;
	assign r16 = rnd16(prod);
	assign q5 = prod >>> 30;
	assign sm_nxt = rnd16(acc_q + prod);
	assign press = s_tdata[96];

	always_comb begin
		held_n = held_q;
		mute_n = mute_q;
		rem_a = frem_q;
		if (press) begin
			if (!held_q) begin
				held_n = 1'b1;
				mute_n = !mute_q;
				rem_a = flen_q;
			end
		end else begin
			held_n = 1'b0;
		end
		lvl_t = mute_n ? ($signed({2'b00, fade_q}) - $signed({2'b00, fstep_q}))
			: ($signed({2'b00, fade_q}) + $signed({2'b00, fstep_q}));
		if (rem_a != 16'd0) begin
			if ((mute_n && lvl_t < 0) || (!mute_n && lvl_t > $signed({2'b00, ONE_C}))) begin
				fade_n = mute_n ? 17'd0 : ONE_C;
				frem_n = 16'd0;
			end else begin
				fade_n = lvl_t[16:0];
				frem_n = rem_a - 16'd1;
			end
		end else begin
			fade_n = mute_n ? 17'd0 : ONE_C;
			frem_n = 16'd0;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			STP_VGAIN: begin
				mul_a = (vcv_q > 0 && vcv_q < VCA_CLAMP) ? 32'(vcv_q + 24'sd5) : 32'sd0;
				mul_b = C10;
			end
			STP_VCA_L:  begin mul_a = 32'(sl_q); mul_b = $signed({14'd0, g_q}); end
			STP_VCA_R:  begin mul_a = 32'(sr_q); mul_b = $signed({14'd0, g_q}); end
			STP_VOL_L:  begin mul_a = 32'(sl_q); mul_b = $signed({14'd0, side_gain_q}); end
			STP_VOL_R:  begin mul_a = 32'(sr_q); mul_b = $signed({14'd0, side_gain_q}); end
			STP_FADE_L: begin mul_a = 32'(sl_q); mul_b = $signed({15'd0, fade_q}); end
			STP_FADE_R: begin mul_a = 32'(sr_q); mul_b = $signed({15'd0, fade_q}); end
			STP_PEAK_L: begin mul_a = $signed({9'd0, pl_q}); mul_b = $signed({15'd0, decay_q}); end
			STP_PEAK_R: begin mul_a = $signed({9'd0, pr_q}); mul_b = $signed({15'd0, decay_q}); end
			STP_SM_A: begin
				mul_a = $signed({8'd0, env_sum[23:1]});
				mul_b = $signed({15'd0, alpha_c});
			end
			STP_SM_B: begin
				mul_a = $signed({9'd0, sm_q});
				mul_b = $signed({15'd0, ONE_C - alpha_c});
			end
			STP_ENV_L: begin mul_a = 32'(sl_q); mul_b = $signed({9'd0, sm_q}); end
			STP_ENV_R: begin mul_a = 32'(sr_q); mul_b = $signed({9'd0, sm_q}); end
			STP_DGAIN: begin
				mul_a = (dpres_q && dcv_q > 0 && dcv_q < DUCK_CLAMP) ?
					32'(dcv_q + 24'sd2) : 32'sd0;
				mul_b = C5;
			end
			STP_DUCK:  begin mul_a = $signed({15'd0, c_q}); mul_b = 32'(duck_w_q); end
			STP_DPROD: begin mul_a = 32'(duck_q); mul_b = $signed({9'd0, sm_q}); end
			STP_FACTOR: begin
				mul_a = (z_q >= 0) ? 32'(z_q) : 32'(28'sd4 - z_q);
				mul_b = C5;
			end
			STP_OUT_L: begin mul_a = 32'(ml_q); mul_b = 32'(factor_q); end
			STP_OUT_R: begin mul_a = 32'(mr_q); mul_b = 32'(factor_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_gain_q <= 18'd39322;
			duck_amount_q <= 17'd45875;
			duck_w_q <= '0;
			decay_q <= 17'd65469;
			alpha_q <= 17'd1311;
			fstep_q <= 17'd298;
			flen_q <= 16'd220;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIDE_GAIN: side_gain_q <= cfg_data;
				REG_DUCK_AMT:  duck_amount_q <= cfg_data[16:0];
				REG_DUCK_W:    duck_w_q <= $signed(cfg_data);
				REG_DECAY:     decay_q <= cfg_data[16:0];
				REG_ALPHA:     alpha_q <= cfg_data[16:0];
				REG_FSTEP:     fstep_q <= cfg_data[16:0];
				REG_FLEN:      flen_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			mvalid_q <= 1'b0;
			pl_q <= '0;
			pr_q <= '0;
			sm_q <= '0;
			fade_q <= ONE_C;
			frem_q <= '0;
			mute_q <= 1'b0;
			held_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!mvalid_q || m_tready))
				mvalid_q <= 1'b1;
			else if (m_tready)
				mvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CALC;
						step_q <= STP_VGAIN;
						held_q <= held_n;
						mute_q <= mute_n;
						fade_q <= fade_n;
						frem_q <= frem_n;
					end
				end
				ST_CALC: begin
					step_q <= step_q + 5'd1;
					if (step_q == STP_OUT_R)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!mvalid_q || m_tready) begin
						state_q <= ST_IDLE;
						step_q <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_CALC) begin
				if (step_q == STP_PEAK_L) begin
					pl_q <= (r16 > 64'(SMAX)) ?
						((SMAX > $signed({1'b0, abs_sat(sl_q)})) ? SMAX[22:0] : abs_sat(sl_q))
						: ((r16[22:0] > abs_sat(sl_q)) ? r16[22:0] : abs_sat(sl_q));
				end
				if (step_q == STP_PEAK_R) begin
					pr_q <= (r16 > 64'(SMAX)) ?
						((SMAX > $signed({1'b0, abs_sat(sr_q)})) ? SMAX[22:0] : abs_sat(sr_q))
						: ((r16[22:0] > abs_sat(sr_q)) ? r16[22:0] : abs_sat(sr_q));
				end
				if (step_q == STP_SM_B)
					sm_q <= sm_nxt[22:0];
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			sl_q <= $signed(s_tdata[23:0]);
			sr_q <= $signed(s_tdata[47:24]);
			ml_q <= $signed(s_tdata[71:48]);
			mr_q <= $signed(s_tdata[95:72]);
			vcv_q <= $signed(s_tdata[120:97]);
			dcv_q <= $signed(s_tdata[144:121]);
			vpres_q <= s_tuser[0];
			dpres_q <= s_tuser[1];
		end
		if (state_q == ST_DONE && (!mvalid_q || m_tready))
			mdata_q <= {mute_q, env_q, or_q, ol_q};
		if (state_q == ST_CALC) begin
			case (step_q)
				STP_VGAIN: begin
					if (!vpres_q) g_q <= {1'b0, ONE_C};
					else if (vcv_q <= 0) g_q <= '0;
					else if (vcv_q >= VCA_CLAMP) g_q <= 18'd131072;
					else g_q <= 18'(prod >>> 25);
				end
				STP_VCA_L, STP_VOL_L: sl_q <= sat_s(r16);
				STP_VCA_R, STP_VOL_R: sr_q <= sat_s(r16);
				STP_FADE_L: sl_q <= r16[SW-1:0];
				STP_FADE_R: sr_q <= r16[SW-1:0];
				STP_SM_A: begin
					acc_q <= prod;
					env_q <= env_sum[23:1];
				end
				STP_ENV_L: sl_q <= sat_s(r16);
				STP_ENV_R: sr_q <= sat_s(r16);
				STP_DGAIN: begin
					if (!dpres_q || dcv_q <= 0) c_q <= '0;
					else if (dcv_q >= DUCK_CLAMP) c_q <= ONE_C;
					else c_q <= 17'(q5);
				end
				STP_DUCK: duck_q <= $signed({3'b000, duck_amount_q}) + 20'(r16);
				STP_DPROD: z_q <= 28'((prod + 64'sd163840) >>> 16);
				STP_FACTOR: begin
					if (z_q >= 0) begin
						factor_q <= (q5 > 64'sd65536) ? 25'sd0 : 25'(64'sd65536 - q5);
					end else begin
						factor_q <= 25'(64'sd65536 + q5);
					end
				end
				STP_OUT_L: ol_q <= sat_s(r16 + 64'(sl_q));
				STP_OUT_R: or_q <= sat_s(r16 + 64'(sr_q));
				default: ;
			endcase
		end
	end

	`SDE_ASSERT(a_idle_step, state_q != ST_IDLE || step_q == STP_VGAIN)
	`SDE_ASSERT(a_fade_range, fade_q <= ONE_C)
	`SDE_ASSERT_NEXT(a_accept_calc, s_tvalid && s_tready, state_q == ST_CALC && step_q == STP_VGAIN)

endmodule
